// ----- hdl/lstrb_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lstrb_pkg
// Shared types, constants and helpers for the log-scaled trace ring buffer.
// ----------------------------------------------------------------------------
package lstrb_pkg;

   localparam int TRACE_DEPTH = 64;
   localparam int SLOT_W      = (TRACE_DEPTH > 1) ? $clog2(TRACE_DEPTH) : 1;
   localparam int COUNT_W     = $clog2(TRACE_DEPTH + 1);

   localparam int SAMPLE_W    = 11;
   localparam int THRESH_IW   = 5;
   localparam int ROW_W       = 6;
   localparam int XPOS_W      = 7;

   localparam logic [15:0]         CLIP_MA  = 16'd2000;
   localparam logic [ROW_W-1:0]    BASE_ROW = 6'd62;   // bottom row 63 minus one
   localparam logic [2:0]          SEARCH_TOP_BIT = 3'd4;

   typedef enum logic [1:0] {
      OP_APPEND  = 2'd0,
      OP_READOUT = 2'd1,
      OP_CLEAR   = 2'd2
   } opcode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_READ,
      ST_LOAD,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic              wr_en;
      logic              clear;
      logic              rd_en;
      logic [ROW_W-1:0]  wr_row;
      logic [SLOT_W-1:0] rd_index;
   } ring_cmd_type;

   // Sorted row thresholds, padded above the clip level so the pad never matches.
   function automatic logic [SAMPLE_W-1:0] thresh_at(input logic [THRESH_IW-1:0] idx);
      logic [SAMPLE_W-1:0] t;
      case (idx)
         5'd0:    t = 11'd4;
         5'd1:    t = 11'd9;
         5'd2:    t = 11'd15;
         5'd3:    t = 11'd21;
         5'd4:    t = 11'd29;
         5'd5:    t = 11'd38;
         5'd6:    t = 11'd49;
         5'd7:    t = 11'd61;
         5'd8:    t = 11'd74;
         5'd9:    t = 11'd90;
         5'd10:   t = 11'd109;
         5'd11:   t = 11'd130;
         5'd12:   t = 11'd154;
         5'd13:   t = 11'd183;
         5'd14:   t = 11'd215;
         5'd15:   t = 11'd253;
         5'd16:   t = 11'd296;
         5'd17:   t = 11'd346;
         5'd18:   t = 11'd404;
         5'd19:   t = 11'd470;
         5'd20:   t = 11'd547;
         5'd21:   t = 11'd636;
         5'd22:   t = 11'd738;
         5'd23:   t = 11'd856;
         5'd24:   t = 11'd992;
         5'd25:   t = 11'd1148;
         5'd26:   t = 11'd1329;
         5'd27:   t = 11'd1538;
         5'd28:   t = 11'd1779;
         default: t = 11'd2047;
      endcase
      return t;
   endfunction

   // base + offset, where the sum stays below twice the depth
   function automatic logic [SLOT_W-1:0] slot_wrap(input logic [SLOT_W:0] sum);
      logic [SLOT_W:0] adj;
      adj = sum;
      if (sum >= (SLOT_W+1)'(TRACE_DEPTH)) begin
         adj = sum - (SLOT_W+1)'(TRACE_DEPTH);
      end
      return adj[SLOT_W-1:0];
   endfunction

endpackage
`default_nettype wire

// ----- hdl/lstrb_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lstrb_if
// Valid/ready channels for command transactions and point transactions.
// ----------------------------------------------------------------------------
interface lstrb_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [15:0] current_ma;

   modport source (output valid, opcode, current_ma, input ready);
   modport sink   (input valid, opcode, current_ma, output ready);
endinterface

interface lstrb_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] point_x;
   logic [5:0] point_y;
   logic       point_valid;
   logic       last_point;

   modport source (output valid, point_x, point_y, point_valid, last_point, input ready);
   modport sink   (input valid, point_x, point_y, point_valid, last_point, output ready);
endinterface
`default_nettype wire

// ----- hdl/log_scaled_trace_ring_buffer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// log_scaled_trace_ring_buffer
// Log-scaled trace store for a scrolling current graph.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one command per transaction: append a milliamp sample,
//   read out the trace, or clear it. rsp_ch carries readout points
//   (x, y, valid, last). Only one command is in work at a time; req_ch.ready
//   is high only while the block is idle.
//   Append: ready stays low from acceptance until the sample's row is
//   written. The row is found by a 5-probe binary search through the
//   threshold table on one comparator, then written to the ring.
//   Clear: takes effect on acceptance. Unused opcode: accepted and ignored.
//   Readout: a run of one point per stored entry, oldest first, last_point on
//   the final one; an empty trace gives a single marker with point_valid low.
//   Each point goes through ring read, output register load and transaction
//   plus receiver stall time, set by the single registered ring read port.
//   A stalled receiver simply holds the current point; nothing is dropped.
//   Reset (synchronous) empties the trace; no clearing pass is needed.
// ----------------------------------------------------------------------------
module log_scaled_trace_ring_buffer (
   input  wire logic   clock,
   input  wire logic   reset,
   lstrb_req_if.sink   req_ch,
   lstrb_rsp_if.source rsp_ch
);

   lstrb_pkg::state_type             state_ff, state_in;
   logic [lstrb_pkg::SLOT_W-1:0]     idx_ff, idx_in;
   logic [lstrb_pkg::XPOS_W-1:0]     x_ff, x_in;
   logic [lstrb_pkg::ROW_W-1:0]      y_ff, y_in;
   logic                             pvalid_ff, pvalid_in;
   logic                             last_ff, last_in;

   lstrb_pkg::ring_cmd_type          ring_cmd;
   logic [lstrb_pkg::COUNT_W-1:0]    fill_count;
   logic [lstrb_pkg::ROW_W-1:0]      rd_row;

   logic                             search_start;
   logic                             search_done;
   logic [lstrb_pkg::THRESH_IW-1:0]  search_count;
   logic [lstrb_pkg::SAMPLE_W-1:0]   clipped;
   logic                             req_fire;

   assign req_fire = req_ch.valid && req_ch.ready;
   assign clipped  = (req_ch.current_ma > lstrb_pkg::CLIP_MA)
                   ? lstrb_pkg::CLIP_MA[lstrb_pkg::SAMPLE_W-1:0]
                   : req_ch.current_ma[lstrb_pkg::SAMPLE_W-1:0];

   lstrb_row_search u_search (
      .clock  (clock),
      .reset  (reset),
      .start  (search_start),
      .sample (clipped),
      .done   (search_done),
      .count  (search_count)
   );

   lstrb_ring u_ring (
      .clock      (clock),
      .reset      (reset),
      .cmd        (ring_cmd),
      .fill_count (fill_count),
      .rd_row     (rd_row)
   );

   always_comb begin
      state_in          = state_ff;
      idx_in            = idx_ff;
      x_in              = x_ff;
      y_in              = y_ff;
      pvalid_in         = pvalid_ff;
      last_in           = last_ff;
      search_start      = 1'b0;
      ring_cmd.wr_en    = 1'b0;
      ring_cmd.clear    = 1'b0;
      ring_cmd.rd_en    = 1'b0;
      ring_cmd.wr_row   = lstrb_pkg::BASE_ROW
                        - lstrb_pkg::ROW_W'(search_count);
      ring_cmd.rd_index = idx_ff;

      case (state_ff)
         lstrb_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (lstrb_pkg::opcode_type'(req_ch.opcode))
                  lstrb_pkg::OP_APPEND: begin
                     search_start = 1'b1;
                     state_in     = lstrb_pkg::ST_SEARCH;
                  end
                  lstrb_pkg::OP_READOUT: begin
                     idx_in = '0;
                     if (fill_count == '0) begin
                        // empty trace: single marker transaction
                        x_in      = '0;
                        y_in      = '0;
                        pvalid_in = 1'b0;
                        last_in   = 1'b1;
                        state_in  = lstrb_pkg::ST_EMIT;
                     end else begin
                        state_in = lstrb_pkg::ST_READ;
                     end
                  end
                  lstrb_pkg::OP_CLEAR: begin
                     ring_cmd.clear = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         lstrb_pkg::ST_SEARCH: begin
            if (search_done) begin
               ring_cmd.wr_en = 1'b1;
               state_in       = lstrb_pkg::ST_IDLE;
            end
         end
         lstrb_pkg::ST_READ: begin
            ring_cmd.rd_en = 1'b1;
            state_in       = lstrb_pkg::ST_LOAD;
         end
         lstrb_pkg::ST_LOAD: begin
            x_in      = lstrb_pkg::XPOS_W'({idx_ff, 1'b0});
            y_in      = rd_row;
            pvalid_in = 1'b1;
            last_in   = ((lstrb_pkg::COUNT_W'(idx_ff) + lstrb_pkg::COUNT_W'(1))
                         == fill_count);
            state_in  = lstrb_pkg::ST_EMIT;
         end
         lstrb_pkg::ST_EMIT: begin
            if (rsp_ch.ready) begin
               if (last_ff) begin
                  state_in = lstrb_pkg::ST_IDLE;
               end else begin
                  idx_in   = idx_ff + lstrb_pkg::SLOT_W'(1);
                  state_in = lstrb_pkg::ST_READ;
               end
            end
         end
         default: begin
            state_in = lstrb_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lstrb_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      idx_ff    <= idx_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      pvalid_ff <= pvalid_in;
      last_ff   <= last_in;
   end

   assign req_ch.ready       = (state_ff == lstrb_pkg::ST_IDLE);
   assign rsp_ch.valid       = (state_ff == lstrb_pkg::ST_EMIT);
   assign rsp_ch.point_x     = x_ff;
   assign rsp_ch.point_y     = y_ff;
   assign rsp_ch.point_valid = pvalid_ff;
   assign rsp_ch.last_point  = last_ff;

endmodule
`default_nettype wire

// ----- hdl/lstrb_row_search.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lstrb_row_search
// Binary search of the threshold table with one shared comparator, one
// probe per cycle. Returns the number of thresholds at or below the sample.
// ----------------------------------------------------------------------------
module lstrb_row_search (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic [lstrb_pkg::SAMPLE_W-1:0]    sample,
   output logic                                   done,
   output logic [lstrb_pkg::THRESH_IW-1:0]        count
);

   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;
   logic [2:0]                         bit_ff, bit_in;
   logic [lstrb_pkg::THRESH_IW-1:0]    pos_ff, pos_in;
   logic [lstrb_pkg::SAMPLE_W-1:0]     sample_ff, sample_in;
   logic [lstrb_pkg::THRESH_IW-1:0]    stride;
   logic [lstrb_pkg::THRESH_IW-1:0]    probe;

   assign stride = lstrb_pkg::THRESH_IW'(1) << bit_ff;
   assign probe  = pos_ff + stride - lstrb_pkg::THRESH_IW'(1);

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      bit_in    = bit_ff;
      pos_in    = pos_ff;
      sample_in = sample_ff;
      if (start) begin
         busy_in   = 1'b1;
         bit_in    = lstrb_pkg::SEARCH_TOP_BIT;
         pos_in    = '0;
         sample_in = sample;
      end else if (busy_ff) begin
         if (lstrb_pkg::thresh_at(probe) <= sample_ff) begin
            pos_in = pos_ff + stride;
         end
         if (bit_ff == 3'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            bit_in = bit_ff - 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      bit_ff    <= bit_in;
      pos_ff    <= pos_in;
      sample_ff <= sample_in;
   end

   assign done  = done_ff;
   assign count = pos_ff;

endmodule
`default_nettype wire

// ----- hdl/lstrb_ring.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lstrb_ring
// Row store with oldest pointer and fill count; overwrites the oldest entry
// once full. Read data is registered.
// ----------------------------------------------------------------------------
module lstrb_ring (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire lstrb_pkg::ring_cmd_type           cmd,
   output logic [lstrb_pkg::COUNT_W-1:0]          fill_count,
   output logic [lstrb_pkg::ROW_W-1:0]            rd_row
);

   logic [lstrb_pkg::ROW_W-1:0]   row_store_ff [lstrb_pkg::TRACE_DEPTH];
   logic [lstrb_pkg::ROW_W-1:0]   rd_row_ff;
   logic [lstrb_pkg::SLOT_W-1:0]  oldest_ff, oldest_in;
   logic [lstrb_pkg::COUNT_W-1:0] fill_ff, fill_in;
   logic [lstrb_pkg::SLOT_W-1:0]  wr_addr;
   logic [lstrb_pkg::SLOT_W-1:0]  rd_addr;
   logic                          full;

   assign full    = (fill_ff == lstrb_pkg::COUNT_W'(lstrb_pkg::TRACE_DEPTH));
   assign rd_addr = lstrb_pkg::slot_wrap((lstrb_pkg::SLOT_W+1)'(oldest_ff)
                                         + (lstrb_pkg::SLOT_W+1)'(cmd.rd_index));

   always_comb begin
      oldest_in = oldest_ff;
      fill_in   = fill_ff;
      wr_addr   = oldest_ff;
      if (cmd.clear) begin
         oldest_in = '0;
         fill_in   = '0;
      end else if (cmd.wr_en) begin
         if (full) begin
            wr_addr   = oldest_ff;
            oldest_in = lstrb_pkg::slot_wrap((lstrb_pkg::SLOT_W+1)'(oldest_ff)
                                             + (lstrb_pkg::SLOT_W+1)'(1));
         end else begin
            wr_addr = lstrb_pkg::slot_wrap((lstrb_pkg::SLOT_W+1)'(oldest_ff)
                                           + (lstrb_pkg::SLOT_W+1)'(fill_ff));
            fill_in = fill_ff + lstrb_pkg::COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oldest_ff <= '0;
         fill_ff   <= '0;
      end else begin
         oldest_ff <= oldest_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en && !cmd.clear) begin
         row_store_ff[wr_addr] <= cmd.wr_row;
      end
      if (cmd.rd_en) begin
         rd_row_ff <= row_store_ff[rd_addr];
      end
   end

   assign fill_count = fill_ff;
   assign rd_row     = rd_row_ff;

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= lstrb_pkg::COUNT_W'(lstrb_pkg::TRACE_DEPTH))
      else $error("fill count above ring depth");

   a_oldest_holds_filling: assert property (@(posedge clock) disable iff (reset)
      (cmd.wr_en && !cmd.clear && !full) |=> $stable(oldest_ff))
      else $error("oldest slot moved before ring was full");

   a_full_stays_full: assert property (@(posedge clock) disable iff (reset)
      (cmd.wr_en && !cmd.clear && full) |=> full)
      else $error("overwrite changed fill count");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |=> (fill_ff == '0) && (oldest_ff == '0))
      else $error("clear left entries behind");

endmodule
`default_nettype wire
